FILE: design/linear_array_deque_with_search_top_macros.svh
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared wrappers for the concurrent checks in the deque RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, muted while reset is low
`define LDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, muted while reset is low
`define LDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ldq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Sizes, operation and status codes, controller states, command/status structs.
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int DEPTH   = 128;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REAR_W  = ADDR_W + 1;   // -1 .. DEPTH-1
    localparam int FRONT_W = ADDR_W + 2;   // -1 .. DEPTH

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_FIRST,
        IDX_FRONT_DEC,
        IDX_REAR_INC,
        IDX_FRONT_INC,
        IDX_REAR_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_FRONT,
        RD_REAR,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        t_idx_op idx_op;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    key_load;
        logic    res_load;
        t_status res_status;
        logic    res_popped;
        logic    res_found;
    } t_dp_cmd;

    typedef struct packed {
        logic never_used;
        logic empty;
        logic front_zero;
        logic rear_full;
        logic match;
        logic last;
    } t_dp_status;

endpackage

FILE: design/ldq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque channels
// Valid/ready request and result channels with their word payloads.
// ----------------------------------------------------------------------------
interface ldq_in_if;
    import ldq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output operation, output data_value, input ready);
    modport sink   (input valid, input operation, input data_value, output ready);
endinterface

interface ldq_out_if;
    import ldq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;

    modport source (output valid, output status, output popped_value, output found,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input found,
                    output ready);
endinterface

FILE: design/ldq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/ldq_dp.sv
`timescale 1ns / 1ps
`include "linear_array_deque_with_search_top_macros.svh"
// ----------------------------------------------------------------------------
// Deque datapath
// Front/rear indices, slot RAM, search walker and result register.
// ----------------------------------------------------------------------------
module ldq_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ldq_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [ldq_pkg::DATA_W-1:0] i_data_value,
    output ldq_pkg::t_dp_status              o_status,
    output ldq_pkg::t_status                 o_res_status,
    output logic signed [ldq_pkg::DATA_W-1:0] o_res_popped,
    output logic                             o_res_found
);
    import ldq_pkg::*;

    logic signed [FRONT_W-1:0] r_front;
    logic signed [REAR_W-1:0]  r_rear;
    logic signed [FRONT_W-1:0] rear_ext;
    logic signed [FRONT_W-1:0] front_dec;
    logic signed [FRONT_W-1:0] front_inc;
    logic signed [REAR_W-1:0]  rear_inc;
    logic signed [REAR_W-1:0]  rear_dec;

    logic [ADDR_W-1:0] r_ptr;
    logic [ADDR_W-1:0] ptr_next;
    logic              r_last;
    logic [DATA_W-1:0] r_key;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;

    t_status           r_res_status;
    logic [DATA_W-1:0] r_res_popped;
    logic              r_res_found;

    assign rear_ext  = FRONT_W'(r_rear);
    assign front_dec = r_front - FRONT_W'(1);
    assign front_inc = r_front + FRONT_W'(1);
    assign rear_inc  = r_rear + REAR_W'(1);
    assign rear_dec  = r_rear - REAR_W'(1);
    assign ptr_next  = r_ptr + ADDR_W'(1);
    assign wr_data   = i_data_value;

    assign o_status.never_used = (r_front == '1) && (r_rear == '1);
    assign o_status.empty      = o_status.never_used || (r_front > rear_ext);
    assign o_status.front_zero = (r_front == '0);
    assign o_status.rear_full  = (r_rear == REAR_W'(DEPTH - 1));
    assign o_status.match      = (rd_data == r_key);
    assign o_status.last       = r_last;

    // indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '1;
            r_rear  <= '1;
        end else begin
            unique case (i_cmd.idx_op)
                IDX_FIRST: begin
                    r_front <= '0;
                    r_rear  <= '0;
                end
                IDX_FRONT_DEC: r_front <= front_dec;
                IDX_REAR_INC:  r_rear  <= rear_inc;
                IDX_FRONT_INC: r_front <= front_inc;
                IDX_REAR_DEC:  r_rear  <= rear_dec;
                default: begin
                end
            endcase
        end
    end

    // write port follows the index move
    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_FIRST: begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            IDX_FRONT_DEC: begin
                wr_en   = 1'b1;
                wr_addr = front_dec[ADDR_W-1:0];
            end
            IDX_REAR_INC: begin
                wr_en   = 1'b1;
                wr_addr = rear_inc[ADDR_W-1:0];
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = '0;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_FRONT: rd_addr = r_front[ADDR_W-1:0];
            RD_REAR:  rd_addr = r_rear[ADDR_W-1:0];
            RD_NEXT:  rd_addr = ptr_next;
            default:  rd_addr = '0;
        endcase
    end

    // search walker and key
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            if (i_cmd.rd_sel == RD_NEXT) begin
                r_ptr  <= ptr_next;
                r_last <= (ptr_next == r_rear[ADDR_W-1:0]);
            end else begin
                r_ptr  <= rd_addr;
                r_last <= (r_front == rear_ext);
            end
        end
        if (i_cmd.key_load) begin
            r_key <= i_data_value;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_popped <= i_cmd.res_popped ? rd_data : '0;
            r_res_found  <= i_cmd.res_found;
        end
    end

    assign o_res_status = r_res_status;
    assign o_res_popped = r_res_popped;
    assign o_res_found  = r_res_found;

    ldq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    `LDQ_ASSERT_IMP(a_front_unused, i_clk, i_rst_n, r_front == '1, r_rear == '1, "front unset with rear set")
    `LDQ_ASSERT_IMP(a_span_order, i_clk, i_rst_n, r_front >= 0, r_front <= rear_ext + FRONT_W'(1), "front passed rear by more than one")
    `LDQ_ASSERT_IMP(a_walk_in_span, i_clk, i_rst_n, i_cmd.rd_en && i_cmd.rd_sel == RD_NEXT, !r_last && (r_ptr < r_rear[ADDR_W-1:0]), "search walked past rear")
endmodule

FILE: design/ldq_ctrl.sv
`timescale 1ns / 1ps
`include "linear_array_deque_with_search_top_macros.svh"
// ----------------------------------------------------------------------------
// Deque controller
// Handshake, operation decode and pop/search sequencing.
// ----------------------------------------------------------------------------
module ldq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ldq_pkg::OP_W-1:0]   i_in_op,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  ldq_pkg::t_dp_status        i_status,
    output ldq_pkg::t_dp_cmd           o_cmd
);
    import ldq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && !i_status.empty) begin
                    if (i_in_op == OP_POP_FRONT || i_in_op == OP_POP_REAR) begin
                        n_state = S_POP;
                    end else if (i_in_op == OP_SEARCH) begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_POP: n_state = S_IDLE;
            S_SEARCH: begin
                if (i_status.match || i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.rd_sel     = RD_FRONT;
        o_cmd.res_status = STAT_OK;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_op)
                        OP_PUSH_FRONT: begin
                            o_cmd.res_load = 1'b1;
                            if (i_status.never_used) begin
                                o_cmd.idx_op = IDX_FIRST;
                            end else if (i_status.front_zero) begin
                                o_cmd.res_status = STAT_REFUSED;
                            end else begin
                                o_cmd.idx_op = IDX_FRONT_DEC;
                            end
                        end
                        OP_PUSH_REAR: begin
                            o_cmd.res_load = 1'b1;
                            if (i_status.never_used) begin
                                o_cmd.idx_op = IDX_FIRST;
                            end else if (i_status.rear_full) begin
                                o_cmd.res_status = STAT_REFUSED;
                            end else begin
                                o_cmd.idx_op = IDX_REAR_INC;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (i_status.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = STAT_EMPTY;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_FRONT;
                                o_cmd.idx_op = IDX_FRONT_INC;
                            end
                        end
                        OP_POP_REAR: begin
                            if (i_status.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = STAT_EMPTY;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_REAR;
                                o_cmd.idx_op = IDX_REAR_DEC;
                            end
                        end
                        OP_SEARCH: begin
                            if (i_status.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = STAT_EMPTY;
                            end else begin
                                o_cmd.rd_en    = 1'b1;
                                o_cmd.rd_sel   = RD_FRONT;
                                o_cmd.key_load = 1'b1;
                            end
                        end
                        default: o_cmd.res_load = 1'b1;  // unused codes: plain ok
                    endcase
                end
            end
            S_POP: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_popped = 1'b1;
            end
            S_SEARCH: begin
                if (i_status.match) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = 1'b1;
                end else if (i_status.last) begin
                    o_cmd.res_load = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = o_cmd.res_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `LDQ_ASSERT_NXT(a_pop_result, i_clk, i_rst_n, r_state == S_POP, r_out_valid, "pop gave no result")
    `LDQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_cmd.res_load, "result overwritten while stalled")
    `LDQ_ASSERT_NXT(a_search_ends, i_clk, i_rst_n, r_state == S_SEARCH, r_state == S_SEARCH || r_out_valid, "search left without a result")
endmodule

FILE: design/linear_array_deque_with_search_top.sv
`timescale 1ns / 1ps
// Deque held in a flat slot RAM; front and rear start at minus one.
// Request channel i_in: operation (push front/rear, pop front/rear, search) and
// data_value; result channel o_out: status, popped_value, found. One result
// word per request word, in order; words move on valid and ready both high.
// Steps from the accepting edge to the result becoming valid:
//   pushes, refused or empty requests and unused codes: result register loaded
//   pops: registered read of the slot RAM, then the result register
//   search: walks k slots (1 .. DEPTH) from the front, one RAM read a cycle,
//   stopping at the first match or at the rear, then the result register.
// A new request is taken once the previous one has produced its result and the
// result register is free or being emptied, so pushes run at one word a cycle.
// Reset (synchronous, active low) empties the deque; slot contents are not
// cleared and are never read before being written.
// A stalled receiver holds the result register and stops new requests.
// ----------------------------------------------------------------------------
// Deque top level
// Joins the controller and datapath to the request and result channels.
// ----------------------------------------------------------------------------
module linear_array_deque_with_search_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ldq_in_if.sink    i_in,
    ldq_out_if.source o_out
);
    import ldq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // controller: handshake and sequencing
    ldq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_op     (i_in.operation),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    // datapath: indices, slot RAM, search walker, result register
    ldq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_value (i_in.data_value),
        .o_status     (dp_status),
        .o_res_status (o_out.status),
        .o_res_popped (o_out.popped_value),
        .o_res_found  (o_out.found)
    );
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque testbench
// Drives push, pop and search words into the deque and checks every result
// word against a cycle-free model of the deque kept inside the bench. Both
// channels idle in random bursts; the last part of the run is free-flowing.
// ----------------------------------------------------------------------------
module testbench;
    import ldq_pkg::*;

    localparam int NO_SLOT         = -1;          // index value of an unused end
    localparam int OP_FIRST_UNUSED = OP_SEARCH + 1;
    localparam int ITEM_TARGET     = 420;         // directed part plus random part
    localparam int CALM_ITEMS      = 60;          // tail of the run with no idling
    localparam int DRAIN_EVERY     = 100;         // sender waits for quiet this often
    localparam int SETTLE_CYCLES   = DEPTH + 16;  // longest search plus margin
    // worst word: full-span search, longest gap, longest stall, many times over
    localparam int CYCLE_LIMIT     = ITEM_TARGET * (DEPTH + 20) * 8;

    // one request word and its pacing
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        int                       gap;     // idle cycles before it is offered
        bit                       drain;   // offer only once all results are in
    } t_request;

    // one result word as the deque should return it
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] popped_value;
        logic                     found;
    } t_outcome;

    logic i_clk;
    logic i_rst_n = 1'b0;

    ldq_in_if  req_ch ();
    ldq_out_if res_ch ();

    linear_array_deque_with_search_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // stimulus side
    t_request                 request_queue [$];
    logic signed [DATA_W-1:0] pushed_pool [$];    // values offered to pushes, for searches
    bit                       gaps_on;
    bit                       drain_next;
    int                       total_items;
    int                       calm_after;

    // checking side
    t_outcome                 awaited_results [$];
    t_outcome                 want;
    logic signed [DATA_W-1:0] slot_copy [DEPTH];
    int                       front_pos = NO_SLOT;
    int                       rear_pos  = NO_SLOT;
    int                       n_taken   = 0;      // request words accepted
    int                       n_done    = 0;      // result words accepted
    int                       fault_count = 0;
    int                       stall_left  = 0;
    int                       cycle_count = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Deque model: indices start at minus one, the array never wraps.
    // ------------------------------------------------------------------------
    function automatic bit deque_empty();
        return (front_pos == NO_SLOT && rear_pos == NO_SLOT) || front_pos > rear_pos;
    endfunction

    function automatic t_outcome deque_step(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] value);
        t_outcome r;
        int       k;
        r.status       = STAT_OK;
        r.popped_value = '0;
        r.found        = 1'b0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (front_pos == NO_SLOT && rear_pos == NO_SLOT) begin
                    // first push ever: both ends land on slot zero, one write
                    front_pos    = 0;
                    rear_pos     = 0;
                    slot_copy[0] = value;
                end else if (op == OP_PUSH_FRONT) begin
                    // front at zero refuses, even when the deque is empty
                    if (front_pos <= 0) begin
                        r.status = STAT_REFUSED;
                    end else begin
                        front_pos            = front_pos - 1;
                        slot_copy[front_pos] = value;
                    end
                end else if (rear_pos >= DEPTH - 1) begin
                    r.status = STAT_REFUSED;
                end else begin
                    rear_pos            = rear_pos + 1;
                    slot_copy[rear_pos] = value;
                end
            end
            OP_POP_FRONT: begin
                if (deque_empty()) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.popped_value = slot_copy[front_pos];
                    front_pos      = front_pos + 1;
                end
            end
            OP_POP_REAR: begin
                if (deque_empty()) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.popped_value = slot_copy[rear_pos];
                    rear_pos       = rear_pos - 1;
                end
            end
            OP_SEARCH: begin
                if (deque_empty()) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (k = front_pos; k <= rear_pos; k++) begin
                        if (slot_copy[k] == value) begin
                            r.found = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;  // unused codes leave everything alone
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(0, 11))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};   // most negative
            1:       return {1'b0, {(DATA_W-1){1'b1}}};   // most positive
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // searches use a value offered to an earlier push about half the time
    function automatic logic signed [DATA_W-1:0] search_word();
        if (pushed_pool.size() > 0 && $urandom_range(0, 1) == 0)
            return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
        return random_word();
    endfunction

    // words from the calm boundary on never get a gap, however long a burst runs
    task automatic add_request(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] value);
        t_request r;
        r.op    = op;
        r.value = value;
        r.drain = drain_next;
        r.gap   = 0;
        if (gaps_on && (request_queue.size() < ITEM_TARGET - CALM_ITEMS)
                && $urandom_range(0, 3) == 0)
            r.gap = $urandom_range(1, 8);
        drain_next = 1'b0;
        request_queue.push_back(r);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)
            pushed_pool.push_back(value);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the queued words; a drain word waits for a quiet deque.
    // Counters are the values from before this edge, so n_taken/n_done plus
    // an acceptance on this edge give a race-free view of what is in flight.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (request_queue.size() == 0) begin
                req_ch.valid <= 1'b0;
            end else if (request_queue[0].gap > 0) begin
                request_queue[0].gap = request_queue[0].gap - 1;
                req_ch.valid <= 1'b0;
            end else if (request_queue[0].drain && (n_taken != n_done || req_ch.valid)) begin
                // a word taken on this edge still has its result to come
                req_ch.valid <= 1'b0;
            end else begin
                req_ch.valid      <= 1'b1;
                req_ch.operation  <= request_queue[0].op;
                req_ch.data_value <= request_queue[0].value;
                void'(request_queue.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result word, then models each accepted request.
    // A result never belongs to a request taken on the same edge, so the
    // check comes first. Also paces the result channel's ready.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no request awaiting it");
                    fault_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        fault_count++;
                    end
                    if (res_ch.popped_value !== want.popped_value) begin
                        $error("popped_value: expected %0d, got %0d",
                               want.popped_value, res_ch.popped_value);
                        fault_count++;
                    end
                    if (res_ch.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, res_ch.found);
                        fault_count++;
                    end
                end
                n_done <= n_done + 1;
            end

            if (req_ch.valid && req_ch.ready) begin
                awaited_results.push_back(deque_step(req_ch.operation, req_ch.data_value));
                n_taken <= n_taken + 1;
            end

            // random stalls, none in the tail of the run
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                res_ch.ready <= 1'b0;
            end else if (n_taken < calm_after && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 7);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int len;
        int c;
        int next_drain;

        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_PUSH_FRONT;
        req_ch.data_value = '0;
        res_ch.ready      = 1'b0;
        gaps_on           = 1'b1;
        drain_next        = 1'b0;

        // Directed: empty handling, unused codes, first push, refusals at
        // front zero, search hits at both ends and a miss, emptying by pops
        // from either side, then refilling an emptied deque from both ends.
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_REAR, '1);
        add_request(OP_SEARCH, '0);
        for (c = OP_FIRST_UNUSED; c < (1 << OP_W); c++)
            add_request(c[OP_W-1:0], $urandom);
        add_request(OP_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        add_request(OP_PUSH_FRONT, 32'sd1);
        add_request(OP_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
        add_request(OP_SEARCH, {1'b1, {(DATA_W-1){1'b0}}});
        add_request(OP_SEARCH, {1'b0, {(DATA_W-1){1'b1}}});
        add_request(OP_SEARCH, '0);
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_FRONT, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_SEARCH, '1);
        add_request(OP_PUSH_FRONT, '1);
        add_request(OP_PUSH_REAR, '0);
        add_request(OP_SEARCH, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_POP_REAR, '0);
        add_request(OP_SEARCH, '0);
        add_request(OP_PUSH_REAR, 32'sh5555_5555);
        add_request(OP_POP_FRONT, '0);

        // Fill to the top so the rear refuses, then search the full span.
        drain_next = 1'b1;
        repeat (DEPTH + 2) add_request(OP_PUSH_REAR, random_word());
        repeat (4) add_request(OP_SEARCH, search_word());
        next_drain = request_queue.size() + DRAIN_EVERY;

        // Random bursts of like operations so the indices wander over the
        // whole array; a little noise of any code in between.
        while (request_queue.size() < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0)
                      && (request_queue.size() < ITEM_TARGET - CALM_ITEMS);
            if (request_queue.size() >= next_drain) begin
                drain_next = 1'b1;
                next_drain = next_drain + DRAIN_EVERY;
            end
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            case (kind)
                0, 1: repeat (2 * len) add_request(OP_PUSH_REAR, random_word());
                2:    repeat (len) add_request(OP_PUSH_FRONT, random_word());
                3, 4: repeat (len) add_request(OP_POP_FRONT, random_word());
                5:    repeat (len) add_request(OP_POP_REAR, random_word());
                6, 7: repeat (len / 3 + 1) add_request(OP_SEARCH, search_word());
                8: begin
                    repeat (len)
                        add_request(OP_W'($urandom_range(0, (1 << OP_W) - 1)),
                                    random_word());
                end
                default: begin
                    // rare long runs: pop or push at the front DEPTH/2 times to move it far
                    if ($urandom_range(0, 1) == 0)
                        repeat (DEPTH / 2) add_request(OP_POP_FRONT, random_word());
                    else
                        repeat (DEPTH / 2) add_request(OP_PUSH_FRONT, random_word());
                end
            endcase
        end

        total_items = request_queue.size();
        calm_after  = total_items - CALM_ITEMS;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_taken == total_items && n_done == total_items);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
